[design/mtld_pkg.sv]
// Shared types and constants for the magic/type/length deframer.
`default_nettype none

package mtld_pkg;

   localparam int unsigned LEN_FIELD_BITS = 32;
   localparam int unsigned MAGIC_BYTES    = 4;
   localparam int unsigned HEADER_BYTES   = 9;

   localparam logic [7:0] TYPE_EVENT = 8'h01;
   localparam logic [7:0] TYPE_VIDEO = 8'h02;

   localparam logic [LEN_FIELD_BITS-1:0] DEFAULT_MAX_LEN = 32'(32 * 1024 * 1024);

   // Position of the final header byte after the magic (type byte is position 0).
   localparam logic [2:0] HEADER_LAST = 3'(HEADER_BYTES - MAGIC_BYTES - 1);

   typedef enum logic [1:0] {
      STATUS_PAYLOAD = 2'd0,
      STATUS_EMPTY   = 2'd1,
      STATUS_DISCARD = 2'd2
   } status_type;

   function automatic logic [7:0] magic_byte(input logic [1:0] idx);
      logic [7:0] value;
      case (idx)
         2'd0:    value = 8'h4C;
         2'd1:    value = 8'h42;
         2'd2:    value = 8'h53;
         default: value = 8'h58;
      endcase
      return value;
   endfunction

   function automatic logic type_emits(input logic [7:0] frame_type);
      return (frame_type == TYPE_EVENT) || (frame_type == TYPE_VIDEO);
   endfunction

endpackage

`default_nettype wire

[design/mtld_if.sv]
// Valid/ready channel interfaces for the deframer's byte, result and register ports.
`default_nettype none

interface mtld_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface mtld_rsp_if;
   import mtld_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   logic       frame_kind;
   logic [7:0] payload_byte;
   logic       first_of_frame;
   logic       last_of_frame;

   modport source (output valid, output status, output frame_kind, output payload_byte,
                   output first_of_frame, output last_of_frame, input ready);
   modport sink   (input valid, input status, input frame_kind, input payload_byte,
                   input first_of_frame, input last_of_frame, output ready);
endinterface

interface mtld_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[design/magic_type_length_deframer.sv]
// Top level of the magic/type/length deframer: hunt, header parse and payload marking.
//
//   port       dir  transaction
//   csr_port   in   max_payload_length write (32 bits)
//   req_port   in   one stream byte
//   rsp_port   out  zero or one result per byte (status, kind, byte, first, last)
//
// One byte per clock while req_port.ready is high: the parser state updates in the accepting
// cycle and any result lands in a single output register, visible the next cycle.
// req_port.ready is low only while that output register is full and not being taken.
// Synchronous reset returns to hunting and loads the default maximum length.
// csr_port is always ready; write it only while the block is idle.
`default_nettype none

module magic_type_length_deframer #(
   parameter int unsigned LENGTH_BITS = 32
) (
   input  wire           clock,
   input  wire           reset,
   mtld_csr_if.sink      csr_port,
   mtld_req_if.sink      req_port,
   mtld_rsp_if.source    rsp_port
);
   import mtld_pkg::*;

   typedef enum logic [1:0] {
      PH_HUNT    = 2'd0,
      PH_HEADER  = 2'd1,
      PH_PAYLOAD = 2'd2
   } phase_type;

   phase_type                   phase_ff,  phase_in;
   logic [1:0]                  magic_ff,  magic_in;
   logic [2:0]                  hdr_pos_ff, hdr_pos_in;
   logic [7:0]                  type_ff,   type_in;
   logic [LEN_FIELD_BITS-1:0]   len_ff,    len_in;
   logic [LENGTH_BITS-1:0]      remain_ff, remain_in;
   logic                        first_ff,  first_in;
   logic [LEN_FIELD_BITS-1:0]   max_len_ff;

   logic                        rsp_valid_ff;
   status_type                  status_ff,  status_in;
   logic                        kind_ff,    kind_in;
   logic [7:0]                  byte_ff,    byte_in;
   logic                        sof_ff,     sof_in;
   logic                        eof_ff,     eof_in;

   logic                        accept;
   logic                        emit;
   logic [7:0]                  b;
   logic [LEN_FIELD_BITS-1:0]   len_new;
   logic                        oversize;
   logic                        last_byte;

   assign csr_port.ready = 1'b1;
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;
   assign b              = req_port.data_byte;

   assign len_new   = {len_ff[LEN_FIELD_BITS-9:0], b};
   assign oversize  = (len_new > max_len_ff) || ((len_new >> LENGTH_BITS) != '0);
   assign last_byte = remain_ff <= LENGTH_BITS'(1);

   always_comb begin
      phase_in   = phase_ff;
      magic_in   = magic_ff;
      hdr_pos_in = hdr_pos_ff;
      type_in    = type_ff;
      len_in     = len_ff;
      remain_in  = remain_ff;
      first_in   = first_ff;
      emit       = 1'b0;
      status_in  = STATUS_PAYLOAD;
      kind_in    = 1'b0;
      byte_in    = 8'h00;
      sof_in     = 1'b0;
      eof_in     = 1'b0;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               hdr_pos_in = hdr_pos_ff + 3'd1;
               if (hdr_pos_ff == 3'd0) begin
                  type_in = b;
                  len_in  = '0;
               end else begin
                  len_in = len_new;
               end
               if (hdr_pos_ff == HEADER_LAST) begin
                  if (oversize) begin
                     phase_in   = PH_HUNT;
                     magic_in   = 2'd0;
                     hdr_pos_in = 3'd0;
                     emit       = 1'b1;
                     status_in  = STATUS_DISCARD;
                  end else if (len_new == '0) begin
                     phase_in   = PH_HUNT;
                     magic_in   = 2'd0;
                     hdr_pos_in = 3'd0;
                     emit       = type_emits(type_ff);
                     status_in  = STATUS_EMPTY;
                     kind_in    = (type_ff == TYPE_VIDEO);
                     eof_in     = 1'b1;
                  end else begin
                     phase_in   = PH_PAYLOAD;
                     hdr_pos_in = 3'd0;
                     remain_in  = LENGTH_BITS'(len_new);
                     first_in   = 1'b1;
                  end
               end
            end
            PH_PAYLOAD: begin
               first_in  = 1'b0;
               remain_in = remain_ff - LENGTH_BITS'(1);
               if (last_byte) begin
                  phase_in   = PH_HUNT;
                  magic_in   = 2'd0;
                  hdr_pos_in = 3'd0;
               end
               emit      = type_emits(type_ff);
               status_in = STATUS_PAYLOAD;
               kind_in   = (type_ff == TYPE_VIDEO);
               byte_in   = b;
               sof_in    = first_ff;
               eof_in    = last_byte;
            end
            default: begin
               // Sliding match; no magic byte repeats, so a mismatch restarts at most one deep.
               phase_in = PH_HUNT;
               if (b == magic_byte(magic_ff)) begin
                  if (magic_ff == 2'(MAGIC_BYTES - 1)) begin
                     magic_in   = 2'd0;
                     phase_in   = PH_HEADER;
                     hdr_pos_in = 3'd0;
                  end else begin
                     magic_in = magic_ff + 2'd1;
                  end
               end else begin
                  magic_in = (b == magic_byte(2'd0)) ? 2'd1 : 2'd0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         magic_ff     <= 2'd0;
         hdr_pos_ff   <= 3'd0;
         first_ff     <= 1'b0;
         max_len_ff   <= DEFAULT_MAX_LEN;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         magic_ff   <= magic_in;
         hdr_pos_ff <= hdr_pos_in;
         first_ff   <= first_in;
         if (csr_port.valid) begin
            max_len_ff <= csr_port.data;
         end
         if (accept && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      type_ff   <= type_in;
      len_ff    <= len_in;
      remain_ff <= remain_in;
      if (accept && emit) begin
         status_ff <= status_in;
         kind_ff   <= kind_in;
         byte_ff   <= byte_in;
         sof_ff    <= sof_in;
         eof_ff    <= eof_in;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.status         = status_ff;
   assign rsp_port.frame_kind     = kind_ff;
   assign rsp_port.payload_byte   = byte_ff;
   assign rsp_port.first_of_frame = sof_ff;
   assign rsp_port.last_of_frame  = eof_ff;

   // A held result must block new bytes so it is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_port.ready) |-> !req_port.ready)
      else $error("deframer accepted a byte while its result was stalled");

   a_remain_live: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_PAYLOAD) |-> (remain_ff != '0))
      else $error("deframer in payload with no bytes remaining");

   a_magic_hunt_only: assert property (@(posedge clock) disable iff (reset)
      (magic_ff != 2'd0) |-> (phase_ff == PH_HUNT))
      else $error("partial magic held outside hunting");

   a_discard_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != STATUS_PAYLOAD) |->
         (byte_ff == 8'h00 && !sof_ff))
      else $error("non-payload result carries payload marks");

   a_reset_hunt: assert property (@(posedge clock)
      reset |=> (phase_ff == PH_HUNT && !rsp_valid_ff))
      else $error("deframer not hunting after reset");

endmodule

`default_nettype wire

[bench/magic_type_length_deframer_test.sv]
// Self-checking testbench for the magic/type/length deframer: random framed streams.
`default_nettype none

module magic_type_length_deframer_test;
   timeunit 1ns;
   timeprecision 1ps;

   import mtld_pkg::*;

   localparam logic [31:0] SYNC_WORD     = 32'h4C42_5358;
   localparam logic [31:0] RESET_LIMIT   = 32'h0200_0000;
   localparam logic [2:0]  HEADER_TAIL   = 3'd5;
   localparam int unsigned HOLD_CYCLES   = 300;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned PHASE_BYTES   = 95;

   typedef enum logic [1:0] {
      SEEK_SYNC   = 2'd0,
      READ_HEADER = 2'd1,
      READ_BODY   = 2'd2
   } parse_state_type;

   typedef struct packed {
      status_type status;
      logic       kind;
      logic [7:0] data;
      logic       first;
      logic       last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset;

   mtld_csr_if csr_bus ();
   mtld_req_if req_bus ();
   mtld_rsp_if rsp_bus ();

   magic_type_length_deframer #(.LENGTH_BITS(32)) uut (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_bus),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // stream bytes waiting for the driver, results waiting for the monitor
   logic [7:0]       stream_q[$];
   frame_result_type results_due[$];

   int unsigned bytes_sent;
   int unsigned bytes_taken;
   int unsigned fail_count;
   int unsigned cycle_count;
   logic        req_taken;
   logic        calm;
   int unsigned hold_ask;
   int unsigned hold_given;
   int unsigned hold_left;

   // shadow of the deframer state
   parse_state_type parse_state;
   logic [1:0]      sync_count;
   logic [2:0]      hdr_pos;
   logic [7:0]      frame_code;
   logic [31:0]     length_acc;
   logic [31:0]     body_left;
   logic            first_flag;
   logic [31:0]     limit_shadow;

   function automatic logic [7:0] sync_byte(input logic [1:0] idx);
      return SYNC_WORD[31 - 8 * idx -: 8];
   endfunction

   function automatic logic code_emits(input logic [7:0] code);
      return (code == TYPE_EVENT) || (code == TYPE_VIDEO);
   endfunction

   task automatic restart_hunt();
      parse_state = SEEK_SYNC;
      sync_count  = 2'd0;
      hdr_pos     = 3'd0;
   endtask

   // advance the shadow parser by one accepted byte and queue any result it causes
   task automatic track_byte(input logic [7:0] b);
      frame_result_type r;
      logic             last;
      r = '0;
      case (parse_state)
         READ_HEADER: begin
            if (hdr_pos == 3'd0) begin
               frame_code = b;
               length_acc = 32'd0;
            end else begin
               length_acc = {length_acc[23:0], b};
            end
            hdr_pos = hdr_pos + 3'd1;
            if (hdr_pos == HEADER_TAIL) begin
               if (length_acc > limit_shadow) begin
                  restart_hunt();
                  r.status = STATUS_DISCARD;
                  results_due.push_back(r);
               end else if (length_acc == 32'd0) begin
                  restart_hunt();
                  if (code_emits(frame_code)) begin
                     r.status = STATUS_EMPTY;
                     r.kind   = (frame_code == TYPE_VIDEO);
                     r.last   = 1'b1;
                     results_due.push_back(r);
                  end
               end else begin
                  parse_state = READ_BODY;
                  hdr_pos     = 3'd0;
                  body_left   = length_acc;
                  first_flag  = 1'b1;
               end
            end
         end
         READ_BODY: begin
            last       = (body_left <= 32'd1);
            r.status   = STATUS_PAYLOAD;
            r.kind     = (frame_code == TYPE_VIDEO);
            r.data     = b;
            r.first    = first_flag;
            r.last     = last;
            first_flag = 1'b0;
            body_left  = body_left - 32'd1;
            if (last) restart_hunt();
            if (code_emits(frame_code)) results_due.push_back(r);
         end
         default: begin
            parse_state = SEEK_SYNC;
            if (b == sync_byte(sync_count)) begin
               if (sync_count == 2'd3) begin
                  sync_count  = 2'd0;
                  parse_state = READ_HEADER;
                  hdr_pos     = 3'd0;
               end else begin
                  sync_count = sync_count + 2'd1;
               end
            end else begin
               sync_count = (b == sync_byte(2'd0)) ? 2'd1 : 2'd0;
            end
         end
      endcase
   endtask

   // monitor: sample every channel at the rising edge
   always @(posedge clock) begin
      frame_result_type got;
      frame_result_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("Regression FAIL");
         $finish;
      end
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status = rsp_bus.status;
            got.kind   = rsp_bus.frame_kind;
            got.data   = rsp_bus.payload_byte;
            got.first  = rsp_bus.first_of_frame;
            got.last   = rsp_bus.last_of_frame;
            if (results_due.size() == 0) begin
               fail_count = fail_count + 1;
               $display({"%0t: unexpected result: expected none, got status=%0d kind=%0b",
                         " byte=%02h first=%0b last=%0b"},
                        $time, got.status, got.kind, got.data, got.first, got.last);
            end else begin
               want = results_due.pop_front();
               if (got !== want) begin
                  fail_count = fail_count + 1;
                  $display({"%0t: result mismatch: expected status=%0d kind=%0b byte=%02h",
                            " first=%0b last=%0b, got status=%0d kind=%0b byte=%02h",
                            " first=%0b last=%0b"},
                           $time, want.status, want.kind, want.data, want.first,
                           want.last, got.status, got.kind, got.data, got.first, got.last);
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) limit_shadow = csr_bus.data;
         if (req_bus.valid && req_bus.ready) begin
            track_byte(req_bus.data_byte);
            bytes_taken <= bytes_taken + 1;
         end
         req_taken <= req_bus.valid && req_bus.ready;
      end
   end

   // driver: offer the next stream byte at the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (stream_q.size() > 0 && (calm || $urandom_range(0, 99) >= 28)) begin
            req_bus.valid     <= 1'b1;
            req_bus.data_byte <= stream_q.pop_front();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // receiver: random back-pressure, plus long holds on request
   always @(negedge clock) begin
      if (hold_given != hold_ask) begin
         hold_left  = HOLD_CYCLES;
         hold_given = hold_given + 1;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 28);
      end
   end

   task automatic push_byte(input logic [7:0] b);
      stream_q.push_back(b);
      bytes_sent = bytes_sent + 1;
   endtask

   task automatic push_header(input logic [7:0] code, input logic [31:0] len);
      int i;
      for (i = 0; i < 4; i++) push_byte(sync_byte(i[1:0]));
      push_byte(code);
      for (i = 3; i >= 0; i--) push_byte(len[8 * i +: 8]);
   endtask

   // one random frame, sometimes preceded by noise or a broken sync word
   task automatic add_frame(input logic [31:0] lim);
      int unsigned pick;
      int unsigned n;
      int unsigned i;
      int unsigned cap;
      logic [7:0]  code;
      logic [31:0] len;
      logic [63:0] span;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++) push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 22) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++) push_byte(sync_byte(i[1:0]));
         if (pick < 17) push_byte(8'($urandom_range(0, 255)));
      end
      pick = $urandom_range(0, 9);
      if (pick < 4)      code = TYPE_EVENT;
      else if (pick < 8) code = TYPE_VIDEO;
      else               code = 8'($urandom_range(0, 255));
      pick = $urandom_range(0, 99);
      if (pick < 15 && lim != 32'hFFFF_FFFF) begin
         span = 64'hFFFF_FFFF - {32'd0, lim};
         if (pick < 4) len = lim + 32'd1;
         else          len = 32'({32'd0, lim} + 64'd1 + ({32'd0, $urandom} % span));
      end else if (pick < 25 || lim == 32'd0) begin
         len = 32'd0;
      end else begin
         cap = (lim < 32'd12) ? lim : 12;
         if (pick < 32 && lim <= 32'd64) len = lim;
         else                            len = $urandom_range(1, cap);
      end
      push_header(code, len);
      if (len != 32'd0 && len <= lim)
         for (i = 0; i < len; i++) push_byte(8'($urandom_range(0, 255)));
   endtask

   // hold off until every byte is taken and every result has come, then let the pipe drain
   task automatic wait_idle();
      @(negedge clock);
      while (bytes_taken != bytes_sent || results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_limit(input logic [31:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin
      int unsigned phase;
      int unsigned target;
      logic [31:0] limit_now;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = 8'h00;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = 32'd0;
      bytes_sent        = 0;
      bytes_taken       = 0;
      fail_count        = 0;
      cycle_count       = 0;
      req_taken         = 1'b0;
      calm              = 1'b0;
      hold_ask          = 0;
      hold_given        = 0;
      hold_left         = 0;
      parse_state       = SEEK_SYNC;
      sync_count        = 2'd0;
      hdr_pos           = 3'd0;
      frame_code        = 8'h00;
      length_acc        = 32'd0;
      body_left         = 32'd0;
      first_flag        = 1'b0;
      limit_shadow      = RESET_LIMIT;
      limit_now         = RESET_LIMIT;

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // repeated first sync byte, then a one-byte event frame
      push_byte(sync_byte(2'd0));
      push_header(TYPE_EVENT, 32'd1);
      push_byte(8'hFF);
      // empty video frame
      push_header(TYPE_VIDEO, 32'd0);
      // all-ones length is over the reset limit
      push_header(8'hFF, 32'hFFFF_FFFF);

      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) add_frame(limit_now);

      for (phase = 0; phase < 6; phase++) begin
         wait_idle();
         case (phase)
            0:       limit_now = 32'd0;
            1:       limit_now = 32'd5;
            2:       limit_now = 32'hFFFF_FFFF;
            3:       limit_now = $urandom_range(1, 40);
            4:       limit_now = 32'd1;
            default: limit_now = RESET_LIMIT;
         endcase
         write_limit(limit_now);
         calm <= (phase == 1);
         // stall the result side while bytes keep coming
         if (phase == 2) hold_ask <= hold_ask + 1;
         target = bytes_sent + PHASE_BYTES;
         while (bytes_sent < target) add_frame(limit_now);
      end

      wait_idle();
      repeat (10) @(negedge clock);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
design/mtld_pkg.sv
design/mtld_if.sv
design/magic_type_length_deframer.sv
bench/magic_type_length_deframer_test.sv
